### hw/rtl/cew_pkg.sv
// Shared widths, types and flag structs for the cotangent edge weight pipeline.
// Used by every module in hw/rtl; depends on nothing.
package cew_pkg;

  localparam int COORD_W  = 24;
  localparam int INDEX_W  = 20;
  localparam int WEIGHT_W = 32;

  // Exact integer widths along the datapath.
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int MAG_W    = SUM_W;
  localparam int HALF_W   = (MAG_W + 1) / 2;
  localparam int HI_W     = MAG_W - HALF_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int S_W      = SQ_W + 2;
  localparam int FRAC_SH  = 30;
  localparam int T_W      = SQ_W + FRAC_SH;
  localparam int Q_W      = 2 * WEIGHT_W;
  localparam int REM_W    = S_W + 1;
  localparam int SQ_REM_W = WEIGHT_W + 1;

  // Register stages in the geometry front end.
  localparam int GEOM_LAT = 7;

  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic [S_W-1:0]             sval_t;
  typedef logic [T_W-1:0]             tval_t;
  typedef logic [Q_W-1:0]             qval_t;
  typedef coord_t [2:0]               vec3_t;
  typedef vec3_t [2:0]                tri_t;

  typedef struct packed {
    index_t a;
    index_t b;
    index_t c;
  } idx3_t;

  // Per-corner decisions that override the computed root.
  typedef struct packed {
    logic degen;
    logic force_max;
    logic force_one;
  } wflag_t;

endpackage

### hw/rtl/cew_geom.sv
// Geometry front end: edge vectors, cross product and corner dot products,
// exact squares by partial products. Depends on cew_pkg.
module cew_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  cew_pkg::idx3_t     in_tag,
  input  cew_pkg::tri_t      in_p,
  output logic               out_valid,
  output cew_pkg::idx3_t     out_tag,
  output cew_pkg::sval_t     out_s,
  output cew_pkg::tval_t     out_t [3],
  output cew_pkg::wflag_t    out_fl [3]
);
  import cew_pkg::*;

  logic [GEOM_LAT-1:0] v;
  idx3_t tag [GEOM_LAT];

  logic signed [DIFF_W-1:0] d_ab [3];
  logic signed [DIFF_W-1:0] d_ac [3];
  logic signed [DIFF_W-1:0] d_bc [3];
  logic signed [PROD_W-1:0] pc1 [3];
  logic signed [PROD_W-1:0] pc2 [3];
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic signed [PROD_W-1:0] pcc [3];
  logic signed [SUM_W-1:0]  cr [3];
  logic signed [SUM_W-1:0]  dt [3];
  logic [MAG_W-1:0]         mg [6];
  logic [2*HI_W-1:0]        hh [6];
  logic [MAG_W-1:0]         hl [6];
  logic [2*HALF_W-1:0]      ll [6];
  logic [SQ_W-1:0]          sq [6];
  logic [2:0]               pos4, pos5, pos6;
  logic                     degen4, degen5, degen6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[GEOM_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      for (int k = 1; k < GEOM_LAT; k++) tag[k] <= tag[k-1];
      for (int i = 0; i < 3; i++) begin
        d_ab[i] <= DIFF_W'(signed'(in_p[1][i])) - DIFF_W'(signed'(in_p[0][i]));
        d_ac[i] <= DIFF_W'(signed'(in_p[2][i])) - DIFF_W'(signed'(in_p[0][i]));
        d_bc[i] <= DIFF_W'(signed'(in_p[2][i])) - DIFF_W'(signed'(in_p[1][i]));
      end
      // Cross terms of (b-a) x (c-a) and the per-axis dot terms.
      for (int i = 0; i < 3; i++) begin
        pc1[i] <= PROD_W'(d_ab[(i+1)%3]) * PROD_W'(d_ac[(i+2)%3]);
        pc2[i] <= PROD_W'(d_ab[(i+2)%3]) * PROD_W'(d_ac[(i+1)%3]);
        pa[i]  <= PROD_W'(d_ab[i]) * PROD_W'(d_ac[i]);
        pb[i]  <= PROD_W'(d_ab[i]) * PROD_W'(d_bc[i]);
        pcc[i] <= PROD_W'(d_ac[i]) * PROD_W'(d_bc[i]);
      end
      for (int i = 0; i < 3; i++) cr[i] <= SUM_W'(pc1[i]) - SUM_W'(pc2[i]);
      dt[0] <= SUM_W'(pa[0]) + SUM_W'(pa[1]) + SUM_W'(pa[2]);
      dt[1] <= -(SUM_W'(pb[0]) + SUM_W'(pb[1]) + SUM_W'(pb[2]));
      dt[2] <= SUM_W'(pcc[0]) + SUM_W'(pcc[1]) + SUM_W'(pcc[2]);
      // Magnitudes; only a positive dot product is ever squared.
      for (int i = 0; i < 3; i++) begin
        mg[i]     <= cr[i][SUM_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
        mg[3+i]   <= (dt[i] > 0) ? MAG_W'(dt[i]) : '0;
        pos4[i]   <= (dt[i] > 0);
      end
      degen4 <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      for (int i = 0; i < 6; i++) begin
        hh[i] <= mg[i][MAG_W-1:HALF_W] * mg[i][MAG_W-1:HALF_W];
        hl[i] <= mg[i][MAG_W-1:HALF_W] * mg[i][HALF_W-1:0];
        ll[i] <= mg[i][HALF_W-1:0] * mg[i][HALF_W-1:0];
      end
      pos5   <= pos4;
      degen5 <= degen4;
      for (int i = 0; i < 6; i++) begin
        sq[i] <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1))
                 + SQ_W'(ll[i]);
      end
      pos6   <= pos5;
      degen6 <= degen5;
      out_s  <= S_W'(sq[0]) + S_W'(sq[1]) + S_W'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        out_t[i]            <= T_W'(sq[3+i]) << FRAC_SH;
        out_fl[i].degen     <= degen6;
        out_fl[i].force_max <= degen6;
        out_fl[i].force_one <= !degen6 && !pos6[i];
      end
    end
  end

  assign out_valid = v[GEOM_LAT-1];
  assign out_tag   = tag[GEOM_LAT-1];

endmodule

### hw/rtl/cew_div.sv
// Pipelined restoring divider, three lanes: q = floor(t / s), one quotient
// bit per stage, with an overflow test up front. Depends on cew_pkg.
module cew_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  cew_pkg::idx3_t     in_tag,
  input  cew_pkg::sval_t     in_s,
  input  cew_pkg::tval_t     in_t [3],
  input  cew_pkg::wflag_t    in_fl [3],
  output logic               out_valid,
  output cew_pkg::idx3_t     out_tag,
  output cew_pkg::qval_t     out_q [3],
  output cew_pkg::wflag_t    out_fl [3]
);
  import cew_pkg::*;

  logic [Q_W:0]     v;
  logic [REM_W-1:0] rem [Q_W][3];
  qval_t            low [Q_W][3];
  sval_t            dsr [Q_W];
  qval_t            quo [Q_W+1][3];
  wflag_t           fl  [Q_W+1][3];
  idx3_t            tag [Q_W+1];
  logic [2:0]       ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Q_W-1:0], in_valid};
    end
  end

  // The quotient needs more than Q_W bits exactly when t / 2^Q_W >= s.
  always_comb begin
    for (int c = 0; c < 3; c++) ovf[c] = (in_t[c][T_W-1:Q_W] >= in_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rem[0][c]          <= REM_W'(in_t[c][T_W-1:Q_W]);
        low[0][c]          <= in_t[c][Q_W-1:0];
        quo[0][c]          <= '0;
        fl[0][c].degen     <= in_fl[c].degen;
        fl[0][c].force_max <= in_fl[c].force_max || (ovf[c] && !in_fl[c].force_one);
        fl[0][c].force_one <= in_fl[c].force_one;
      end
      dsr[0] <= in_s;
      tag[0] <= in_tag;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [REM_W-1:0] sh [3];
    logic [2:0]       ge;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        sh[c] = {rem[k-1][c][REM_W-2:0], low[k-1][c][Q_W-1]};
        ge[c] = (sh[c] >= REM_W'(dsr[k-1]));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          quo[k][c] <= {quo[k-1][c][Q_W-2:0], ge[c]};
          fl[k][c]  <= fl[k-1][c];
        end
        tag[k] <= tag[k-1];
      end
    end

    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int c = 0; c < 3; c++) begin
            rem[k][c] <= ge[c] ? (sh[c] - REM_W'(dsr[k-1])) : sh[c];
            low[k][c] <= low[k-1][c] << 1;
          end
          dsr[k] <= dsr[k-1];
        end
      end
    end
  end

  assign out_valid = v[Q_W];
  assign out_tag   = tag[Q_W];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_q[c]  = quo[Q_W][c];
      out_fl[c] = fl[Q_W][c];
    end
  end

endmodule

### hw/rtl/cew_isqrt.sv
// Pipelined integer square root, three lanes, one root bit per stage
// (two radicand bits consumed each stage). Depends on cew_pkg.
module cew_isqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  cew_pkg::idx3_t     in_tag,
  input  cew_pkg::qval_t     in_q [3],
  input  cew_pkg::wflag_t    in_fl [3],
  output logic               out_valid,
  output cew_pkg::idx3_t     out_tag,
  output cew_pkg::weight_t   out_root [3],
  output cew_pkg::wflag_t    out_fl [3]
);
  import cew_pkg::*;

  logic [WEIGHT_W:0]   v;
  qval_t               rad  [WEIGHT_W][3];
  logic [SQ_REM_W-1:0] rr   [WEIGHT_W][3];
  weight_t             root [WEIGHT_W+1][3];
  wflag_t              fl   [WEIGHT_W+1][3];
  idx3_t               tag  [WEIGHT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[WEIGHT_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rad[0][c]  <= in_q[c];
        rr[0][c]   <= '0;
        root[0][c] <= '0;
        fl[0][c]   <= in_fl[c];
      end
      tag[0] <= in_tag;
    end
  end

  for (genvar k = 1; k <= WEIGHT_W; k++) begin : g_stage
    logic [SQ_REM_W+1:0] sh [3];
    logic [SQ_REM_W+1:0] trial [3];
    logic [2:0]          ge;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        sh[c]    = {rr[k-1][c], rad[k-1][c][Q_W-1:Q_W-2]};
        trial[c] = (SQ_REM_W+2)'({root[k-1][c], 2'b01});
        ge[c]    = (sh[c] >= trial[c]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          root[k][c] <= {root[k-1][c][WEIGHT_W-2:0], ge[c]};
          fl[k][c]   <= fl[k-1][c];
        end
        tag[k] <= tag[k-1];
      end
    end

    if (k < WEIGHT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int c = 0; c < 3; c++) begin
            rr[k][c]  <= SQ_REM_W'(ge[c] ? (sh[c] - trial[c]) : sh[c]);
            rad[k][c] <= rad[k-1][c] << 2;
          end
        end
      end
    end
  end

  assign out_valid = v[WEIGHT_W];
  assign out_tag   = tag[WEIGHT_W];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_root[c] = root[WEIGHT_W][c];
      out_fl[c]   = fl[WEIGHT_W][c];
    end
  end

endmodule

### hw/rtl/cotangent_edge_weights.sv
// Top level of the cotangent edge weight pipeline: handshake, pipeline
// enable, final weight selection and output register. Depends on cew_pkg,
// cew_geom, cew_div and cew_isqrt.
//
//   channel   direction  handshake              word
//   input     in         in_valid / in_ready    three indices, nine coordinates
//   output    out        out_valid / out_ready  three indices, three weights, two flags
//
// One triangle word enters per cycle while in_ready is high. From acceptance
// to out_valid a word passes through 7 geometry stages, 65 divider stages
// (overflow test plus one quotient bit each), 33 root stages and the output
// register. The whole pipeline advances together on one enable. It keeps
// moving while the output register is free, is being read, or while the
// last stage holds a bubble; only a held result with a valid word behind it
// stops it, and then in_ready drops. Reset clears the valid bits only.
//
// Each weight is floor(sqrt(floor(t / s))), where s = |(b-a) x (c-a)|^2
// and t = dot^2 * 2^30 for a positive corner dot product. That equals the
// half cotangent in Q16.16 truncated toward zero. A quotient of 2^64 or
// more saturates; a non-positive dot product or a zero root gives one LSB;
// a zero cross product marks the triangle degenerate and saturates all.
module cotangent_edge_weights (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cew_pkg::index_t     vertex_a_index,
  input  cew_pkg::index_t     vertex_b_index,
  input  cew_pkg::index_t     vertex_c_index,
  input  cew_pkg::coord_t     ax,
  input  cew_pkg::coord_t     ay,
  input  cew_pkg::coord_t     az,
  input  cew_pkg::coord_t     bx,
  input  cew_pkg::coord_t     by_coord,
  input  cew_pkg::coord_t     bz,
  input  cew_pkg::coord_t     cx,
  input  cew_pkg::coord_t     cy,
  input  cew_pkg::coord_t     cz,
  output logic                out_valid,
  input  logic                out_ready,
  output cew_pkg::index_t     out_a_index,
  output cew_pkg::index_t     out_b_index,
  output cew_pkg::index_t     out_c_index,
  output cew_pkg::weight_t    weight_ab,
  output cew_pkg::weight_t    weight_bc,
  output cew_pkg::weight_t    weight_ca,
  output logic                degenerate,
  output logic                saturated
);
  import cew_pkg::*;

  logic    adv;
  tri_t    tri_in;
  idx3_t   tag_in;

  logic    g_valid, d_valid, r_valid;
  idx3_t   g_tag, d_tag, r_tag;
  sval_t   g_s;
  tval_t   g_t [3];
  wflag_t  g_fl [3];
  qval_t   d_q [3];
  wflag_t  d_fl [3];
  weight_t r_root [3];
  wflag_t  r_fl [3];
  weight_t wsel [3];

  // Corner 0 is a, 1 is b, 2 is c; axis 0 is x.
  assign tri_in[0][0] = ax;
  assign tri_in[0][1] = ay;
  assign tri_in[0][2] = az;
  assign tri_in[1][0] = bx;
  assign tri_in[1][1] = by_coord;
  assign tri_in[1][2] = bz;
  assign tri_in[2][0] = cx;
  assign tri_in[2][1] = cy;
  assign tri_in[2][2] = cz;

  assign tag_in.a = vertex_a_index;
  assign tag_in.b = vertex_b_index;
  assign tag_in.c = vertex_c_index;

  // The pipeline may shift unless a held result would be overwritten.
  assign adv      = !out_valid || out_ready || !r_valid;
  assign in_ready = adv;

  cew_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .in_tag    (tag_in),
    .in_p      (tri_in),
    .out_valid (g_valid),
    .out_tag   (g_tag),
    .out_s     (g_s),
    .out_t     (g_t),
    .out_fl    (g_fl)
  );

  cew_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (g_valid),
    .in_tag    (g_tag),
    .in_s      (g_s),
    .in_t      (g_t),
    .in_fl     (g_fl),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .out_q     (d_q),
    .out_fl    (d_fl)
  );

  cew_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid),
    .in_tag    (d_tag),
    .in_q      (d_q),
    .in_fl     (d_fl),
    .out_valid (r_valid),
    .out_tag   (r_tag),
    .out_root  (r_root),
    .out_fl    (r_fl)
  );

  // Saturation wins over the one-LSB floor, which also covers a zero root.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      priority if (r_fl[c].force_max) begin
        wsel[c] = '1;
      end else if (r_fl[c].force_one || (r_root[c] == '0)) begin
        wsel[c] = weight_t'(1);
      end else begin
        wsel[c] = r_root[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_a_index <= r_tag.a;
      out_b_index <= r_tag.b;
      out_c_index <= r_tag.c;
      weight_bc   <= wsel[0];
      weight_ca   <= wsel[1];
      weight_ab   <= wsel[2];
      degenerate  <= r_fl[0].degen;
      saturated   <= r_fl[0].force_max || r_fl[1].force_max || r_fl[2].force_max;
    end
  end

`ifndef NO_ASSERTIONS
  a_degen_all_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> saturated && (weight_ab == '1) && (weight_bc == '1)
      && (weight_ca == '1))
    else $error("degenerate triangle without saturated weights");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight_ab != '0) && (weight_bc != '0) && (weight_ca != '0))
    else $error("weight below one LSB");

  a_sat_has_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (weight_ab == '1) || (weight_bc == '1) || (weight_ca == '1))
    else $error("saturated flag without a clipped weight");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && r_valid |-> !in_ready)
    else $error("input taken while the pipeline must hold");

  a_hold_keeps_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && r_valid |=> r_valid && $stable(r_tag))
    else $error("last pipeline stage changed during a stall");
`endif

endmodule
